// File: src/swbr_pkg.sv
`default_nettype none
package swbr_pkg;

    localparam int CMD_WRITE  = 0;
    localparam int CMD_SAMPLE = 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 29;
    localparam int COEF_W     = 23;
    localparam int OFFS_W     = 29;
    localparam int SIZE_W     = 9;
    localparam int DST_W      = 7;
    localparam int PIX_W      = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_A       = 3'd0,
        CFG_COEF_B       = 3'd1,
        CFG_OFFSET_COL   = 3'd2,
        CFG_OFFSET_ROW   = 3'd3,
        CFG_IMAGE_WIDTH  = 3'd4,
        CFG_IMAGE_HEIGHT = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic             cmd;
        logic [7:0]       src_row;
        logic [7:0]       src_col;
        logic [7:0]       in_red;
        logic [7:0]       in_green;
        logic [7:0]       in_blue;
        logic [DST_W-1:0] dst_row;
        logic [DST_W-1:0] dst_col;
    } t_in;

    typedef struct packed {
        logic [DST_W-1:0] out_row;
        logic [DST_W-1:0] out_col;
        logic [7:0]       out_red;
        logic [7:0]       out_green;
        logic [7:0]       out_blue;
    } t_out;

endpackage
`default_nettype wire

// File: src/swbr_ram.sv
`default_nettype none
module swbr_ram #(
    parameter int W     = 24,
    parameter int DEPTH = 16384
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [W-1:0]             i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [W-1:0]             o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// File: src/similarity_warp_bilinear_resampler.sv
// A sample request passes every stage register before its result reaches o_out_valid.
// Throughput: one request per cycle while o_in_stall is low; the frame store is four
// banks split by row and column parity, so all four neighbors are read in the same cycle.
// Write requests leave no result and update the store in the third stage.
// Reset (synchronous, active low) clears stage valids and loads the default transform;
// frame store contents stay undefined until written. FRAME_DIM must be a power of two.
`default_nettype none
module similarity_warp_bilinear_resampler #(
    parameter int FRAME_DIM = 256,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire swbr_pkg::t_in                   i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output swbr_pkg::t_out                       o_out_data,
    input  wire logic                            i_cfg_we,
    input  wire logic [swbr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [swbr_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import swbr_pkg::*;

    localparam int F    = FRAC_BITS;
    localparam int AW   = $clog2(FRAME_DIM);
    localparam int XW   = ((AW > 8) ? AW : 8) + 1;
    localparam int BAW  = 2 * (AW - 1);
    localparam int BDEP = FRAME_DIM * FRAME_DIM / 4;
    localparam int MW   = COEF_W + 8;
    localparam int PW   = MW + 2;
    localparam int IW   = PW - F;
    localparam int WW   = F + 2;
    localparam int PWW  = 2 * WW;
    localparam int VW   = PWW + 9;
    localparam int SW   = VW + 2;

    // configuration
    logic signed [COEF_W-1:0] r_coef_a, r_coef_b;
    logic signed [OFFS_W-1:0] r_offs_col, r_offs_row;
    logic [SIZE_W-1:0]        r_img_w, r_img_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a   <= COEF_W'(1 << F);
            r_coef_b   <= '0;
            r_offs_col <= '0;
            r_offs_row <= '0;
            r_img_w    <= SIZE_W'(256);
            r_img_h    <= SIZE_W'(256);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_COEF_A:       r_coef_a   <= i_cfg_wdata[COEF_W-1:0];
                CFG_COEF_B:       r_coef_b   <= i_cfg_wdata[COEF_W-1:0];
                CFG_OFFSET_COL:   r_offs_col <= i_cfg_wdata[OFFS_W-1:0];
                CFG_OFFSET_ROW:   r_offs_row <= i_cfg_wdata[OFFS_W-1:0];
                CFG_IMAGE_WIDTH:  r_img_w    <= i_cfg_wdata[SIZE_W-1:0];
                CFG_IMAGE_HEIGHT: r_img_h    <= i_cfg_wdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // stage valids and flow control
    logic r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;
    t_in  r1_d, r2_d, r3_d;

    assign rdy7 = !r7_v || !i_out_stall;
    assign rdy6 = !r6_v || rdy7;
    assign rdy5 = !r5_v || rdy6;
    assign rdy4 = !r4_v || rdy5;
    assign rdy3 = !r3_v || rdy4;
    assign rdy2 = !r2_v || rdy3;
    assign rdy1 = !r1_v || rdy2;
    assign o_in_stall = !rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0; r2_v <= 1'b0; r3_v <= 1'b0; r4_v <= 1'b0;
            r5_v <= 1'b0; r6_v <= 1'b0; r7_v <= 1'b0;
        end else begin
            if (rdy1) r1_v <= i_in_valid;
            if (rdy2) r2_v <= r1_v;
            if (rdy3) r3_v <= r2_v;
            if (rdy4) r4_v <= r3_v && (r3_d.cmd == 1'(CMD_SAMPLE));
            if (rdy5) r5_v <= r4_v;
            if (rdy6) r6_v <= r5_v;
            if (rdy7) r7_v <= r6_v;
        end
    end

    // stage 1: transform products
    logic signed [MW-1:0] r1_ac, r1_br, r1_bc, r1_ar;
    logic signed [7:0]    s0_c, s0_r;

    assign s0_c = signed'({1'b0, i_in_data.dst_col});
    assign s0_r = signed'({1'b0, i_in_data.dst_row});

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_d  <= i_in_data;
            r1_ac <= r_coef_a * s0_c;
            r1_br <= r_coef_b * s0_r;
            r1_bc <= r_coef_b * s0_c;
            r1_ar <= r_coef_a * s0_r;
        end
    end

    // stage 2: source positions
    logic signed [PW-1:0] r2_pc, r2_pr;

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r2_d  <= r1_d;
            r2_pc <= PW'(r1_ac) - PW'(r1_br) + PW'(r_offs_col);
            r2_pr <= PW'(r1_bc) + PW'(r1_ar) + PW'(r_offs_row);
        end
    end

    // stage 3: truncate toward zero, signed fraction
    logic signed [IW-1:0] r3_ir, r3_ic;
    logic signed [F:0]    r3_fr, r3_fc;
    logic                 s2_adj_r, s2_adj_c;

    assign s2_adj_r = r2_pr[PW-1] && (|r2_pr[F-1:0]);
    assign s2_adj_c = r2_pc[PW-1] && (|r2_pc[F-1:0]);

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r3_d  <= r2_d;
            r3_ir <= signed'(r2_pr[PW-1:F]) + signed'({{(IW-1){1'b0}}, s2_adj_r});
            r3_ic <= signed'(r2_pc[PW-1:F]) + signed'({{(IW-1){1'b0}}, s2_adj_c});
            r3_fr <= signed'({s2_adj_r, r2_pr[F-1:0]});
            r3_fc <= signed'({s2_adj_c, r2_pc[F-1:0]});
        end
    end

    // stage 3 -> 4: bounds, bank addressing, store writes and reads
    logic signed [IW:0]   s3_ir0, s3_ir1, s3_ic0, s3_ic1, s3_hlim, s3_wlim, s3_fd;
    logic [1:0]           s3_okr, s3_okc;
    logic [XW-1:0]        s3_sr, s3_sc;
    logic                 s3_wr_ok;
    logic [3:0]           s3_we;
    logic [BAW-1:0]       s3_raddr [4];
    logic [BAW-1:0]       s3_waddr;
    logic [PIX_W-1:0]     s3_wdata;
    logic [PIX_W-1:0]     s4_rd [4];
    logic signed [WW-1:0] s3_one;

    assign s3_fd   = (IW+1)'(FRAME_DIM);
    assign s3_hlim = ((IW+1)'(r_img_h) > s3_fd) ? s3_fd : (IW+1)'(r_img_h);
    assign s3_wlim = ((IW+1)'(r_img_w) > s3_fd) ? s3_fd : (IW+1)'(r_img_w);
    assign s3_ir0  = (IW+1)'(r3_ir);
    assign s3_ic0  = (IW+1)'(r3_ic);
    assign s3_ir1  = s3_ir0 + (IW+1)'(1);
    assign s3_ic1  = s3_ic0 + (IW+1)'(1);
    assign s3_okr[0] = !s3_ir0[IW] && (s3_ir0 < s3_hlim);
    assign s3_okr[1] = !s3_ir1[IW] && (s3_ir1 < s3_hlim);
    assign s3_okc[0] = !s3_ic0[IW] && (s3_ic0 < s3_wlim);
    assign s3_okc[1] = !s3_ic1[IW] && (s3_ic1 < s3_wlim);
    assign s3_one  = signed'({2'b01, {F{1'b0}}});

    assign s3_sr    = XW'(r3_d.src_row);
    assign s3_sc    = XW'(r3_d.src_col);
    assign s3_wr_ok = r3_v && (r3_d.cmd == 1'(CMD_WRITE)) && rdy4
                      && (s3_sr < XW'(FRAME_DIM)) && (s3_sc < XW'(FRAME_DIM));
    assign s3_waddr = {s3_sr[AW-1:1], s3_sc[AW-1:1]};
    assign s3_wdata = {r3_d.in_blue, r3_d.in_green, r3_d.in_red};

    // bank index is {row parity, column parity}
    always_comb begin
        logic [IW:0] rsel, csel;
        for (int b = 0; b < 4; b++) begin
            rsel = (r3_ir[0] == b[1]) ? s3_ir0 : s3_ir1;
            csel = (r3_ic[0] == b[0]) ? s3_ic0 : s3_ic1;
            s3_raddr[b] = {rsel[AW-1:1], csel[AW-1:1]};
            s3_we[b]    = s3_wr_ok && (s3_sr[0] == b[1]) && (s3_sc[0] == b[0]);
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_bank
        swbr_ram #(.W(PIX_W), .DEPTH(BDEP)) u_bank (
            .i_clk   (i_clk),
            .i_we    (s3_we[g]),
            .i_waddr (s3_waddr),
            .i_wdata (s3_wdata),
            .i_re    (rdy4),
            .i_raddr (s3_raddr[g]),
            .o_rdata (s4_rd[g])
        );
    end

    logic [DST_W-1:0]     r4_row, r4_col, r5_row, r5_col, r6_row, r6_col;
    logic [1:0]           r4_okr, r4_okc;
    logic                 r4_rp, r4_cp;
    logic signed [WW-1:0] r4_wr [2];
    logic signed [WW-1:0] r4_wc [2];

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r4_row   <= r3_d.dst_row;
            r4_col   <= r3_d.dst_col;
            r4_okr   <= s3_okr;
            r4_okc   <= s3_okc;
            r4_rp    <= r3_ir[0];
            r4_cp    <= r3_ic[0];
            r4_wr[0] <= s3_one - WW'(r3_fr);
            r4_wr[1] <= WW'(r3_fr);
            r4_wc[0] <= s3_one - WW'(r3_fc);
            r4_wc[1] <= WW'(r3_fc);
        end
    end

    // stage 5: neighbor select, weight products; neighbor k = {row step, col step}
    logic [PIX_W-1:0]      r5_pix [4];
    logic signed [PWW-1:0] r5_w [4];

    always_ff @(posedge i_clk) begin
        if (rdy5) begin
            r5_row <= r4_row;
            r5_col <= r4_col;
            for (int k = 0; k < 4; k++) begin
                r5_pix[k] <= (r4_okr[k / 2] && r4_okc[k % 2])
                             ? s4_rd[{r4_rp ^ k[1], r4_cp ^ k[0]}] : '0;
                r5_w[k]   <= r4_wr[k / 2] * r4_wc[k % 2];
            end
        end
    end

    // stage 6: channel products
    logic signed [VW-1:0] r6_p [4][3];

    always_ff @(posedge i_clk) begin
        if (rdy6) begin
            r6_row <= r5_row;
            r6_col <= r5_col;
            for (int k = 0; k < 4; k++) begin
                for (int ch = 0; ch < 3; ch++) begin
                    r6_p[k][ch] <= signed'({1'b0, r5_pix[k][8*ch +: 8]}) * r5_w[k];
                end
            end
        end
    end

    // stage 7: sum, clamp, output register
    logic signed [SW-1:0] s6_sum [3];
    logic [7:0]           s6_ch [3];
    logic signed [SW-1:0] s6_top;
    t_out                 r7_d;

    assign s6_top = signed'(SW'(255) << (2 * F));

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            s6_sum[ch] = SW'(r6_p[0][ch]) + SW'(r6_p[1][ch])
                       + SW'(r6_p[2][ch]) + SW'(r6_p[3][ch]);
            if (s6_sum[ch] < 0) begin
                s6_ch[ch] = '0;
            end else if (s6_sum[ch] >= s6_top) begin
                s6_ch[ch] = 8'hFF;
            end else begin
                s6_ch[ch] = s6_sum[ch][2*F +: 8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy7) begin
            r7_d.out_row   <= r6_row;
            r7_d.out_col   <= r6_col;
            r7_d.out_red   <= s6_ch[0];
            r7_d.out_green <= s6_ch[1];
            r7_d.out_blue  <= s6_ch[2];
        end
    end

    assign o_out_valid = r7_v;
    assign o_out_data  = r7_d;

    a_one_bank_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(s3_we))
        else $error("more than one frame store bank written");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r1_v && r2_v && r3_v && r7_v && i_out_stall))
        else $error("input stalled while pipeline has room");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_v && rdy4 && (r3_d.cmd == 1'(CMD_WRITE))) |=> !r4_v)
        else $error("write request produced a result");
endmodule
`default_nettype wire

// File: tb/sv/tb_similarity_warp_bilinear_resampler.sv
`default_nettype none
import swbr_pkg::*;

class warp_scoreboard;
    logic [PIX_W-1:0] pixels [65536];
    longint           coef_a, coef_b, offs_col, offs_row;
    int unsigned      img_w, img_h;
    t_out             pending [$];
    int               errs;
    int               results_seen;

    function new();
        coef_a   = 65536;
        coef_b   = 0;
        offs_col = 0;
        offs_row = 0;
        img_w    = 256;
        img_h    = 256;
        errs     = 0;
        results_seen = 0;
    endfunction

    function void set_cfg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] v);
        case (idx)
            CFG_COEF_A:       coef_a   = longint'($signed(v[COEF_W-1:0]));
            CFG_COEF_B:       coef_b   = longint'($signed(v[COEF_W-1:0]));
            CFG_OFFSET_COL:   offs_col = longint'($signed(v[OFFS_W-1:0]));
            CFG_OFFSET_ROW:   offs_row = longint'($signed(v[OFFS_W-1:0]));
            CFG_IMAGE_WIDTH:  img_w    = 32'(v[SIZE_W-1:0]);
            CFG_IMAGE_HEIGHT: img_h    = 32'(v[SIZE_W-1:0]);
            default: ;
        endcase
    endfunction

    // truncate toward zero, signed remainder kept as fraction
    function longint trunc_q16(longint p, output longint f);
        longint ip;
        ip = (p < 0) ? -((-p) >>> 16) : (p >>> 16);
        f  = p - ip * 65536;
        return ip;
    endfunction

    function void map_pos(int r, int c, output longint ir, output longint ic,
                          output longint fr, output longint fc);
        longint pc, pr;
        pc = coef_a * c - coef_b * r + offs_col;
        pr = coef_b * c + coef_a * r + offs_row;
        ir = trunc_q16(pr, fr);
        ic = trunc_q16(pc, fc);
    endfunction

    function bit in_image(longint r, longint c);
        longint h, w;
        h = (img_h > 256) ? 256 : img_h;
        w = (img_w > 256) ? 256 : img_w;
        return !(r < 0 || r >= h || c < 0 || c >= w);
    endfunction

    function logic [PIX_W-1:0] pixel_at(longint r, longint c);
        if (!in_image(r, c))
            return '0;
        return pixels[int'(r * 256 + c)];
    endfunction

    function void note_request(t_in x);
        longint ir, ic, fr, fc, wr0, wr1, wc0, wc1, v00, v01, v10, v11, val;
        logic [PIX_W-1:0] p00, p01, p10, p11;
        logic [7:0] ch_res [3];
        t_out e;
        if (x.cmd == CMD_WRITE) begin
            pixels[{x.src_row, x.src_col}] = {x.in_blue, x.in_green, x.in_red};
            return;
        end
        map_pos(x.dst_row, x.dst_col, ir, ic, fr, fc);
        wr0 = 65536 - fr; wr1 = fr;
        wc0 = 65536 - fc; wc1 = fc;
        p00 = pixel_at(ir, ic);
        p01 = pixel_at(ir, ic + 1);
        p10 = pixel_at(ir + 1, ic);
        p11 = pixel_at(ir + 1, ic + 1);
        for (int ch = 0; ch < 3; ch++) begin
            v00 = (p00 >> (8 * ch)) & 255;
            v01 = (p01 >> (8 * ch)) & 255;
            v10 = (p10 >> (8 * ch)) & 255;
            v11 = (p11 >> (8 * ch)) & 255;
            val = v00 * (wr0 * wc0) + v01 * (wr0 * wc1)
                + v10 * (wr1 * wc0) + v11 * (wr1 * wc1);
            if (val < 0)
                ch_res[ch] = 8'd0;
            else if (val >= (longint'(255) <<< 32))
                ch_res[ch] = 8'd255;
            else
                ch_res[ch] = val[39:32];
        end
        e.out_row   = x.dst_row;
        e.out_col   = x.dst_col;
        e.out_red   = ch_res[0];
        e.out_green = ch_res[1];
        e.out_blue  = ch_res[2];
        pending.push_back(e);
    endfunction

    function void check_result(t_out got);
        t_out e;
        results_seen++;
        if (pending.size() == 0) begin
            errs++;
            if (errs <= 10)
                $display("unexpected result row=%0d col=%0d rgb=%h/%h/%h", got.out_row,
                         got.out_col, got.out_red, got.out_green, got.out_blue);
            return;
        end
        e = pending.pop_front();
        if (got.out_row !== e.out_row || got.out_col !== e.out_col ||
            got.out_red !== e.out_red || got.out_green !== e.out_green ||
            got.out_blue !== e.out_blue) begin
            errs++;
            if (errs <= 10)
                $display("mismatch exp r%0d c%0d %h/%h/%h got r%0d c%0d %h/%h/%h",
                         e.out_row, e.out_col, e.out_red, e.out_green, e.out_blue,
                         got.out_row, got.out_col, got.out_red, got.out_green, got.out_blue);
        end
    endfunction
endclass

module tb_similarity_warp_bilinear_resampler;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;
    localparam int NUM_ITEMS  = 1550;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  in_valid;
    logic                  o_in_stall;
    t_in                   in_data;
    logic                  o_out_valid;
    logic                  out_stall;
    t_out                  o_out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    warp_scoreboard sb = new();
    bit written [65536];
    int burst_left, n_req, n_samples, n_writes, n_settings, idle_cyc;
    int stall_mode;
    int stall_cnt = 0;

    similarity_warp_bilinear_resampler dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_data (o_out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_wdata(cfg_wdata)
    );

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    // receiver stall pattern, mode redrawn at random whenever stall_cnt runs out
    always @(negedge i_clk) begin
        if (stall_cnt == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_cnt  = 64;
        end
        stall_cnt--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 7) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= stall_cnt[2];
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall)
            sb.check_result(o_out_data);
    end

    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall))
            idle_cyc = 0;
        else
            idle_cyc++;
        if (idle_cyc >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_request(t_in x);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= x;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(x);
        n_req++;
        if (x.cmd == CMD_WRITE) n_writes++; else n_samples++;
        @(negedge i_clk);
    endtask

    task automatic write_pixel(int r, int c);
        t_in x;
        x = t_in'({$urandom, $urandom});
        x.cmd     = CMD_WRITE;
        x.src_row = r[7:0];
        x.src_col = c[7:0];
        written[{x.src_row, x.src_col}] = 1'b1;
        send_request(x);
    endtask

    // writes any in-image neighbor not yet stored, then samples
    task automatic sample_at(int r, int c);
        longint ir, ic, fr, fc;
        t_in x;
        sb.map_pos(r, c, ir, ic, fr, fc);
        for (int dr = 0; dr < 2; dr++)
            for (int dc = 0; dc < 2; dc++)
                if (sb.in_image(ir + dr, ic + dc) &&
                    !written[int'((ir + dr) * 256 + ic + dc)])
                    write_pixel(int'(ir + dr), int'(ic + dc));
        x = t_in'({$urandom, $urandom});
        x.cmd     = CMD_SAMPLE;
        x.dst_row = r[DST_W-1:0];
        x.dst_col = c[DST_W-1:0];
        send_request(x);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= v;
        sb.set_cfg(idx, v);
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_transform(int a, int b, int oc, int orow, int w, int h);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        cfg_write(CFG_COEF_A, CFG_DATA_W'(a));
        cfg_write(CFG_COEF_B, CFG_DATA_W'(b));
        cfg_write(CFG_OFFSET_COL, CFG_DATA_W'(oc));
        cfg_write(CFG_OFFSET_ROW, CFG_DATA_W'(orow));
        cfg_write(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
        cfg_write(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        n_settings++;
    endtask

    initial begin
        int a, b, oc, orow, w, h, n;
        i_rst_n    = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_we     = 1'b0;
        cfg_idx    = '0;
        cfg_wdata  = '0;
        burst_left = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset transform: identity over the full store
        write_pixel(255, 255);
        write_pixel(0, 0);
        sample_at(0, 0);
        sample_at(127, 127);
        sample_at(111, 0);
        sample_at(0, 111);

        // shrink and rotate with negative fractional offset
        set_transform(32'h8000, 32'h8000, -32'h18000, 32'h7FFF, 256, 256);
        sample_at(0, 0);
        sample_at(5, 3);
        sample_at(127, 127);

        // extreme coefficients and offsets, everything lands outside
        set_transform(-4194304, 4194303, 268435455, -268435456, 256, 256);
        sample_at(0, 0);
        sample_at(127, 127);
        set_transform(4194303, -4194304, -268435456, 268435455, 256, 256);
        sample_at(127, 0);
        sample_at(0, 127);

        // one-pixel image, empty image, oversized image
        set_transform(65536, 0, 0, 0, 1, 1);
        sample_at(0, 0);
        sample_at(1, 1);
        set_transform(65536, 0, 0, 0, 0, 0);
        sample_at(0, 0);
        set_transform(65536, 0, 32'h8000, 200 << 16, 511, 300);
        sample_at(55, 60);
        sample_at(60, 60);

        while (n_req < NUM_ITEMS) begin
            a    = $signed(32'h10000) + $signed($urandom_range(0, 32'h30000)) - 32'h18000;
            b    = $signed($urandom_range(0, 32'h10000)) - 32'h8000;
            oc   = $signed($urandom_range(0, 32'h800000)) - 32'h400000;
            orow = $signed($urandom_range(0, 32'h800000)) - 32'h400000;
            w    = ($urandom_range(0, 4) == 0) ? 256 : $urandom_range(1, 24);
            h    = ($urandom_range(0, 4) == 0) ? 256 : $urandom_range(1, 24);
            if ($urandom_range(0, 5) == 0) begin
                a = $signed($urandom) >>> 9;
                b = $signed($urandom) >>> 9;
            end
            set_transform(a, b, oc, orow, w, h);
            n = $urandom_range(40, 150);
            for (int k = 0; k < n && n_req < NUM_ITEMS; k++) begin
                if ($urandom_range(0, 6) == 0)
                    write_pixel($urandom_range(0, 255), $urandom_range(0, 255));
                else
                    sample_at($urandom_range(0, 127), $urandom_range(0, 127));
            end
        end

        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (sb.pending.size() != 0) sb.errs++;
        $display("%0d requests (%0d samples, %0d pixel writes) over %0d transform settings",
                 n_req, n_samples, n_writes, n_settings);
        $display("%0d results checked, %0d mismatches", sb.results_seen, sb.errs);
        if (sb.errs == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire
